// File: src/rfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_pkg
// Types, codes and fixed-point constants of the rotameter flow correction.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int H_W      = 16;
    localparam int D_W      = 24;
    localparam int P_W      = 24;
    localparam int T_W      = 24;
    localparam int FLOW_W   = 32;
    localparam int ST_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam int NUM_W  = 51;
    localparam int DEN_W  = 53;
    localparam int LO_W   = 24;
    localparam int QUO_W  = 64;
    localparam int ROOT_W = 32;
    localparam int SUM_W  = 57;
    localparam int RN_W   = 35;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURVE_MODE       = 2'd0,
        CFG_PRESSURE_UNIT    = 2'd1,
        CFG_TEMPERATURE_UNIT = 2'd2,
        CFG_DIRECT_FLOW_UNIT = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] CM_CURVE_ONE = 2'd0;
    localparam logic [1:0] CM_CURVE_TWO = 2'd1;
    localparam logic [1:0] PU_INH2O     = 2'd1;
    localparam logic [1:0] PU_MMHG      = 2'd2;
    localparam logic [1:0] TU_CELSIUS   = 2'd1;
    localparam logic [1:0] TU_KELVIN    = 2'd2;
    localparam logic       DU_CFM       = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_OK              = 2'd0,
        ST_BAD_PRESSURE    = 2'd1,
        ST_BAD_TEMPERATURE = 2'd2,
        ST_SATURATED       = 2'd3
    } t_status;

    localparam logic [9:0]  CFM_MUL     = 10'd708;
    localparam logic [3:0]  CFM_BIAS    = 4'd12;
    localparam logic [32:0] DIV25_MUL   = 33'd5497558138;
    localparam int          DIV25_SHIFT = 37;
    localparam logic [4:0]  DIV25       = 5'd25;

    localparam logic [26:0] NUM_SCALE_PSI   = 27'd662500;
    localparam logic [26:0] NUM_SCALE_OTHER = 27'd66250000;
    localparam logic [19:0] DEN_SCALE_PSI   = 20'd147;
    localparam logic [19:0] DEN_SCALE_INH2O = 20'd409248;
    localparam logic [19:0] DEN_SCALE_MMHG  = 20'd760137;

    typedef struct packed {
        logic [1:0] curve_mode;
        logic [1:0] pressure_unit;
        logic [1:0] temperature_unit;
        logic       direct_flow_unit;
    } t_cfg;

    typedef struct packed {
        logic [H_W-1:0]        float_height;
        logic [D_W-1:0]        direct_flow;
        logic [P_W-1:0]        ambient_pressure;
        logic [P_W-1:0]        pressure_drop;
        logic signed [T_W-1:0] temperature;
    } t_in_item;

    typedef struct packed {
        logic [FLOW_W-1:0] raw_flow;
        logic [FLOW_W-1:0] corrected_flow;
        logic [ST_W-1:0]   status;
    } t_out_item;

    typedef struct packed {
        logic [FLOW_W-1:0] raw_flow;
        logic              bad_pressure;
        logic              bad_temperature;
        logic              saturated;
    } t_side;

    function automatic logic [12:0] k3_coef(input logic sel);
        return sel ? 13'd2806 : 13'd6275;
    endfunction

    function automatic logic [29:0] k2_coef(input logic sel);
        return sel ? 30'd600283850 : 30'd292142471;
    endfunction

    function automatic logic [38:0] k1_coef(input logic sel);
        return sel ? 39'd464667100000 : 39'd460585834000;
    endfunction

    function automatic logic signed [49:0] k0_coef(input logic sel);
        return sel ? 50'sd462658380000000 : -50'sd12471051000000;
    endfunction

endpackage
`default_nettype wire

// File: src/rfc_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface rfc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/rfc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_front
// Six-stage front end: raw flow from the curves or the direct reading,
// unit conversion, and the numerator and denominator of the correction ratio.
// ----------------------------------------------------------------------------
module rfc_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_en,
    input  wire logic                             i_valid,
    input  wire rfc_pkg::t_in_item                i_item,
    input  wire rfc_pkg::t_cfg                    i_cfg,
    output logic                                  o_valid,
    output logic [rfc_pkg::NUM_W-1:0]             o_num,
    output logic [rfc_pkg::DEN_W-1:0]             o_den,
    output logic                                  o_ratio_sat,
    output rfc_pkg::t_side                        o_side
);

    logic                                 sel;
    logic                                 is_curve;
    assign sel      = i_cfg.curve_mode[0];
    assign is_curve = (i_cfg.curve_mode == rfc_pkg::CM_CURVE_ONE) ||
                      (i_cfg.curve_mode == rfc_pkg::CM_CURVE_TWO);

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    // stage 1
    logic [15:0]        r_h1;
    logic [23:0]        r_d1, r_p1, r_dp1;
    logic signed [23:0] r_t1;

    // stage 2
    logic [15:0]                      r_h2;
    logic [31:0]                      r_hsq2;
    logic [54:0]                      r_hk1_2;
    logic [33:0]                      r_y2;
    logic [23:0]                      r_d2;
    logic signed [24:0]               r_net2;
    logic signed [rfc_pkg::RN_W-1:0]  r_rn2;
    logic signed [rfc_pkg::RN_W-1:0]  t_ext;
    logic signed [rfc_pkg::RN_W-1:0]  n_rn2;

    // stage 3
    logic [47:0]                  r_hcube3;
    logic [61:0]                  r_hsqk2_3;
    logic [54:0]                  r_hk1_3;
    logic [66:0]                  r_prod3;
    logic [33:0]                  r_y3;
    logic [23:0]                  r_d3;
    logic [rfc_pkg::NUM_W-1:0]    r_num3;
    logic [rfc_pkg::DEN_W-1:0]    r_den3;
    logic                         r_badp3, r_badt3;
    logic [26:0]                  num_scale;
    logic [19:0]                  den_scale;

    // stage 4
    logic [60:0]                  r_hk3_4;
    logic [rfc_pkg::SUM_W-1:0]    r_part4;
    logic [29:0]                  r_q0_4;
    logic [5:0]                   r_rem4;
    logic [23:0]                  r_d4;
    logic [rfc_pkg::NUM_W-1:0]    r_num4;
    logic [rfc_pkg::DEN_W-1:0]    r_den4;
    logic                         r_rsat4, r_badp4, r_badt4;
    logic [29:0]                  n_q0;
    logic [33:0]                  n_rem;

    // stage 5
    logic signed [rfc_pkg::SUM_W-1:0] r_sum5;
    logic signed [rfc_pkg::SUM_W-1:0] k0_ext;
    logic [29:0]                      r_qd5;
    logic [23:0]                      r_d5;
    logic [rfc_pkg::NUM_W-1:0]        r_num5;
    logic [rfc_pkg::DEN_W-1:0]        r_den5;
    logic                             r_rsat5, r_badp5, r_badt5;

    // stage 6
    logic [rfc_pkg::NUM_W-1:0]  r_num6;
    logic [rfc_pkg::DEN_W-1:0]  r_den6;
    logic                       r_rsat6;
    rfc_pkg::t_side             r_side6;
    logic [55:0]                rounded;
    rfc_pkg::t_side             n_side6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_comb begin
        t_ext = rfc_pkg::RN_W'(r_t1);
        case (i_cfg.temperature_unit)
            rfc_pkg::TU_CELSIUS: n_rn2 = t_ext * 35'sd900 + 35'sd62976000;
            rfc_pkg::TU_KELVIN:  n_rn2 = t_ext * 35'sd900 + 35'sd42240;
            default:             n_rn2 = t_ext * 35'sd500 + 35'sd58880000;
        endcase
    end

    always_comb begin
        case (i_cfg.pressure_unit)
            rfc_pkg::PU_INH2O: begin
                num_scale = rfc_pkg::NUM_SCALE_OTHER;
                den_scale = rfc_pkg::DEN_SCALE_INH2O;
            end
            rfc_pkg::PU_MMHG: begin
                num_scale = rfc_pkg::NUM_SCALE_OTHER;
                den_scale = rfc_pkg::DEN_SCALE_MMHG;
            end
            default: begin
                num_scale = rfc_pkg::NUM_SCALE_PSI;
                den_scale = rfc_pkg::DEN_SCALE_PSI;
            end
        endcase
    end

    assign n_q0   = r_prod3[rfc_pkg::DIV25_SHIFT +: 30];
    assign n_rem  = r_y3 - 34'(n_q0) * 34'(rfc_pkg::DIV25);
    assign k0_ext = rfc_pkg::SUM_W'(rfc_pkg::k0_coef(sel));

    always_comb begin
        rounded = 56'(r_sum5[55:0]) + (56'(1) << 39);
        n_side6.bad_pressure    = r_badp5;
        n_side6.bad_temperature = r_badt5;
        n_side6.saturated       = 1'b0;
        if (is_curve) begin
            if (r_sum5 < 0) begin
                n_side6.raw_flow  = '0;
                n_side6.saturated = 1'b1;
            end else begin
                n_side6.raw_flow = rfc_pkg::FLOW_W'(rounded[55:40]);
            end
        end else if (i_cfg.direct_flow_unit == rfc_pkg::DU_CFM) begin
            n_side6.raw_flow = rfc_pkg::FLOW_W'(r_qd5);
        end else begin
            n_side6.raw_flow = rfc_pkg::FLOW_W'(r_d5);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h1  <= i_item.float_height;
            r_d1  <= i_item.direct_flow;
            r_p1  <= i_item.ambient_pressure;
            r_dp1 <= i_item.pressure_drop;
            r_t1  <= i_item.temperature;

            r_h2    <= r_h1;
            r_hsq2  <= 32'(r_h1) * 32'(r_h1);
            r_hk1_2 <= 55'(r_h1) * 55'(rfc_pkg::k1_coef(sel));
            r_y2    <= 34'(r_d1) * 34'(rfc_pkg::CFM_MUL) + 34'(rfc_pkg::CFM_BIAS);
            r_d2    <= r_d1;
            r_net2  <= $signed({1'b0, r_p1}) - $signed({1'b0, r_dp1});
            r_rn2   <= n_rn2;

            r_hcube3  <= 48'(r_hsq2) * 48'(r_h2);
            r_hsqk2_3 <= 62'(r_hsq2) * 62'(rfc_pkg::k2_coef(sel));
            r_hk1_3   <= r_hk1_2;
            r_prod3   <= 67'(r_y2) * 67'(rfc_pkg::DIV25_MUL);
            r_y3      <= r_y2;
            r_d3      <= r_d2;
            r_num3    <= 51'(r_net2[23:0]) * 51'(num_scale);
            r_den3    <= 53'(den_scale) * 53'(r_rn2[32:0]);
            r_badp3   <= (r_net2 <= 25'sd0);
            r_badt3   <= (r_rn2 <= 35'sd0);

            r_hk3_4 <= 61'(r_hcube3) * 61'(rfc_pkg::k3_coef(sel));
            r_part4 <= rfc_pkg::SUM_W'(r_hsqk2_3 >> 8) + rfc_pkg::SUM_W'(r_hk1_3);
            r_q0_4  <= n_q0;
            r_rem4  <= n_rem[5:0];
            r_d4    <= r_d3;
            r_num4  <= r_num3;
            r_den4  <= r_den3;
            r_rsat4 <= (rfc_pkg::DEN_W'(r_num3[rfc_pkg::NUM_W-1:rfc_pkg::LO_W]) >= r_den3);
            r_badp4 <= r_badp3;
            r_badt4 <= r_badt3;

            r_sum5  <= $signed(rfc_pkg::SUM_W'(r_hk3_4 >> 8) + r_part4) + k0_ext;
            r_qd5   <= r_q0_4 + 30'(r_rem4 >= 6'(rfc_pkg::DIV25));
            r_d5    <= r_d4;
            r_num5  <= r_num4;
            r_den5  <= r_den4;
            r_rsat5 <= r_rsat4;
            r_badp5 <= r_badp4;
            r_badt5 <= r_badt4;

            r_num6  <= r_num5;
            r_den6  <= r_den5;
            r_rsat6 <= r_rsat5;
            r_side6 <= n_side6;
        end
    end

    assign o_valid     = r_v6;
    assign o_num       = r_num6;
    assign o_den       = r_den6;
    assign o_ratio_sat = r_rsat6;
    assign o_side      = r_side6;

endmodule
`default_nettype wire

// File: src/rfc_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_divider
// Restoring divider, one quotient bit per stage: floor(num * 2^40 / den).
// ----------------------------------------------------------------------------
module rfc_divider (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic [rfc_pkg::NUM_W-1:0]      i_num,
    input  wire logic [rfc_pkg::DEN_W-1:0]      i_den,
    input  wire logic                           i_ratio_sat,
    input  wire rfc_pkg::t_side                 i_side,
    output logic                                o_valid,
    output logic [rfc_pkg::QUO_W-1:0]           o_ratio,
    output rfc_pkg::t_side                      o_side
);

    localparam int NW = rfc_pkg::NUM_W;
    localparam int DW = rfc_pkg::DEN_W;
    localparam int LW = rfc_pkg::LO_W;
    localparam int QW = rfc_pkg::QUO_W;

    logic           r_v    [1:QW];
    logic [QW-1:0]  r_quo  [1:QW];
    logic           r_sat  [1:QW];
    rfc_pkg::t_side r_side [1:QW];
    logic [DW-1:0]  r_rem  [1:QW-1];
    logic [DW-1:0]  r_den  [1:QW-1];
    logic [LW-1:0]  r_lo   [1:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic           v_in;
        logic [DW-1:0]  rem_in;
        logic [DW-1:0]  den_in;
        logic [LW-1:0]  lo_in;
        logic [QW-1:0]  quo_in;
        logic           sat_in;
        rfc_pkg::t_side side_in;
        logic [DW:0]    trial;
        logic           ge;

        if (k == 0) begin : g_head
            assign v_in    = i_valid;
            assign rem_in  = DW'(i_num[NW-1:LW]);
            assign den_in  = i_den;
            assign lo_in   = i_num[LW-1:0];
            assign quo_in  = '0;
            assign sat_in  = i_ratio_sat;
            assign side_in = i_side;
        end else begin : g_tail
            assign v_in    = r_v[k];
            assign rem_in  = r_rem[k];
            assign den_in  = r_den[k];
            assign lo_in   = r_lo[k];
            assign quo_in  = r_quo[k];
            assign sat_in  = r_sat[k];
            assign side_in = r_side[k];
        end

        assign trial = {rem_in, lo_in[LW-1]};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k+1]  <= {quo_in[QW-2:0], ge};
                r_sat[k+1]  <= sat_in;
                r_side[k+1] <= side_in;
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
                    r_den[k+1] <= den_in;
                    r_lo[k+1]  <= {lo_in[LW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        o_side           = r_side[QW];
        o_side.saturated = r_side[QW].saturated | r_sat[QW];
    end

    assign o_valid = r_v[QW];
    assign o_ratio = r_sat[QW] ? '1 : r_quo[QW];

endmodule
`default_nettype wire

// File: src/rfc_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rfc_sqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [rfc_pkg::QUO_W-1:0]    i_radicand,
    input  wire rfc_pkg::t_side               i_side,
    output logic                              o_valid,
    output logic [rfc_pkg::ROOT_W-1:0]        o_root,
    output rfc_pkg::t_side                    o_side
);

    localparam int QW = rfc_pkg::QUO_W;
    localparam int RW = rfc_pkg::ROOT_W;

    logic           r_v    [1:RW];
    logic [QW-1:0]  r_res  [1:RW];
    rfc_pkg::t_side r_side [1:RW];
    logic [QW-1:0]  r_rem  [1:RW-1];

    for (genvar k = 0; k < RW; k++) begin : g_step
        localparam logic [QW-1:0] BIT = QW'(1) << (QW - 2 - 2 * k);

        logic           v_in;
        logic [QW-1:0]  rem_in;
        logic [QW-1:0]  res_in;
        rfc_pkg::t_side side_in;
        logic [QW:0]    sum;
        logic           ge;

        if (k == 0) begin : g_head
            assign v_in    = i_valid;
            assign rem_in  = i_radicand;
            assign res_in  = '0;
            assign side_in = i_side;
        end else begin : g_tail
            assign v_in    = r_v[k];
            assign rem_in  = r_rem[k];
            assign res_in  = r_res[k];
            assign side_in = r_side[k];
        end

        assign sum = {1'b0, res_in} + {1'b0, BIT};
        assign ge  = ({1'b0, rem_in} >= sum);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[k+1]  <= ge ? (res_in >> 1) + BIT : res_in >> 1;
                r_side[k+1] <= side_in;
            end
        end

        if (k < RW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= ge ? rem_in - sum[QW-1:0] : rem_in;
                end
            end
        end
    end

    assign o_valid = r_v[RW];
    assign o_root  = r_res[RW][RW-1:0];
    assign o_side  = r_side[RW];

endmodule
`default_nettype wire

// File: src/rotameter_flow_correction_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotameter_flow_correction_unit
// Rotameter gas flow with pressure and temperature correction.
//
// One transaction on i_in_ch carries a float height or direct flow reading,
// ambient pressure, pressure drop and temperature. Exactly one transaction
// on o_out_ch follows, with raw flow, corrected flow and a status code.
// Units and curve are chosen through the write port i_cfg_we / i_cfg_idx /
// i_cfg_data; change them only while no transaction is in flight.
// From input acceptance to output valid a transaction passes 6 front-end
// stages, 64 divider stages (one quotient bit each), 32 square-root stages
// (one root bit each), a multiply stage and the output register.
// Throughput is one transaction per cycle while the skid register is empty;
// the whole datapath advances as one pipeline.
// Synchronous reset clears all valid bits and the registers to curve one,
// psi, Fahrenheit and litres per minute.
// When the receiver stalls, one extra transaction lands in a skid register;
// after that the pipeline and i_in_ch.ready hold until the output drains.
// ----------------------------------------------------------------------------
module rotameter_flow_correction_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    rfc_stream_if.sink                               i_in_ch,
    rfc_stream_if.source                             o_out_ch,
    input  wire logic                                i_cfg_we,
    input  wire logic [rfc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [rfc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    rfc_pkg::t_cfg r_cfg;

    logic w_en;

    logic                           f_valid;
    logic [rfc_pkg::NUM_W-1:0]      f_num;
    logic [rfc_pkg::DEN_W-1:0]      f_den;
    logic                           f_ratio_sat;
    rfc_pkg::t_side                 f_side;

    logic                           d_valid;
    logic [rfc_pkg::QUO_W-1:0]      d_ratio;
    rfc_pkg::t_side                 d_side;

    logic                           s_valid;
    logic [rfc_pkg::ROOT_W-1:0]     s_root;
    rfc_pkg::t_side                 s_side;

    logic                           r_vm1;
    logic [63:0]                    r_prod_m1;
    rfc_pkg::t_side                 r_side_m1;

    logic [64:0]                    rounded;
    logic [44:0]                    corr;
    logic                           ovf;
    logic                           w_fin_v;
    rfc_pkg::t_out_item             w_fin;

    logic                           r_out_v;
    rfc_pkg::t_out_item             r_out;
    logic                           r_skid_v;
    rfc_pkg::t_out_item             r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (rfc_pkg::t_cfg_idx'(i_cfg_idx))
                rfc_pkg::CFG_CURVE_MODE:       r_cfg.curve_mode       <= i_cfg_data;
                rfc_pkg::CFG_PRESSURE_UNIT:    r_cfg.pressure_unit    <= i_cfg_data;
                rfc_pkg::CFG_TEMPERATURE_UNIT: r_cfg.temperature_unit <= i_cfg_data;
                rfc_pkg::CFG_DIRECT_FLOW_UNIT: r_cfg.direct_flow_unit <= i_cfg_data[0];
            endcase
        end
    end

    assign w_en          = !r_skid_v;
    assign i_in_ch.ready = w_en;

    rfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_in_ch.valid),
        .i_item      (i_in_ch.data),
        .i_cfg       (r_cfg),
        .o_valid     (f_valid),
        .o_num       (f_num),
        .o_den       (f_den),
        .o_ratio_sat (f_ratio_sat),
        .o_side      (f_side)
    );

    rfc_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (f_valid),
        .i_num       (f_num),
        .i_den       (f_den),
        .i_ratio_sat (f_ratio_sat),
        .i_side      (f_side),
        .o_valid     (d_valid),
        .o_ratio     (d_ratio),
        .o_side      (d_side)
    );

    rfc_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (d_valid),
        .i_radicand (d_ratio),
        .i_side     (d_side),
        .o_valid    (s_valid),
        .o_root     (s_root),
        .o_side     (s_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm1 <= 1'b0;
        end else if (w_en) begin
            r_vm1 <= s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod_m1 <= 64'(s_side.raw_flow) * 64'(s_root);
            r_side_m1 <= s_side;
        end
    end

    always_comb begin
        rounded = {1'b0, r_prod_m1} + (65'(1) << 19);
        corr    = rounded[64:20];
        ovf     = |corr[44:32];
        w_fin.raw_flow = r_side_m1.raw_flow;
        if (r_side_m1.bad_pressure) begin
            w_fin.corrected_flow = '0;
            w_fin.status         = rfc_pkg::ST_BAD_PRESSURE;
        end else if (r_side_m1.bad_temperature) begin
            w_fin.corrected_flow = '0;
            w_fin.status         = rfc_pkg::ST_BAD_TEMPERATURE;
        end else begin
            w_fin.corrected_flow = ovf ? '1 : corr[31:0];
            w_fin.status         = (ovf || r_side_m1.saturated) ? rfc_pkg::ST_SATURATED
                                                                : rfc_pkg::ST_OK;
        end
    end

    assign w_fin_v = r_vm1 && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_out_ch.ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= w_fin_v;
            end
        end else if (w_fin_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_out_ch.ready) begin
            r_out <= r_skid_v ? r_skid : w_fin;
        end else if (w_fin_v) begin
            r_skid <= w_fin;
        end
    end

    assign o_out_ch.valid = r_out_v;
    assign o_out_ch.data  = r_out;

endmodule
`default_nettype wire
